FILE: rtl/eeg_serial_frame_parser_core_defines.svh
`ifndef EEG_SERIAL_FRAME_PARSER_CORE_DEFINES_SVH
`define EEG_SERIAL_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ESFP_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ESFP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/esfp_pkg.sv
package esfp_pkg;

  localparam int unsigned PosW = 6;
  localparam int unsigned ByteW = 8;
  localparam int unsigned StatusW = 2;

  typedef logic [PosW-1:0] pos_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [StatusW-1:0] status_t;

  localparam status_t STATUS_OK = 2'd0;
  localparam status_t STATUS_CHECKSUM_ERR = 2'd1;
  localparam status_t STATUS_POOR_SIGNAL = 2'd2;

  localparam pos_t POS_SYNC0 = 6'd0;
  localparam pos_t POS_SYNC1 = 6'd1;
  localparam pos_t POS_LENGTH = 6'd2;
  localparam pos_t POS_CODE = 6'd3;
  localparam pos_t POS_QUALITY = 6'd4;
  localparam pos_t POS_ASIC0 = 6'd5;
  localparam pos_t POS_ASIC1 = 6'd6;
  localparam pos_t POS_ATTENTION = 6'd32;
  localparam pos_t POS_MEDITATION = 6'd34;
  localparam pos_t POS_CHECKSUM = 6'd35;

  localparam byte_t SYNC_BYTE = 8'hAA;
  localparam byte_t LENGTH_BYTE = 8'h20;
  localparam byte_t CODE_BYTE = 8'h02;
  localparam byte_t ASIC0_BYTE = 8'h83;
  localparam byte_t ASIC1_BYTE = 8'h18;

  typedef struct packed {
    logic    valid;
    status_t status;
    byte_t   attention;
    byte_t   meditation;
    byte_t   signal_quality;
  } result_t;

  function automatic logic is_poor_quality(input byte_t q);
    return (q == 8'h1D) || (q == 8'h36) || (q == 8'h37) || (q == 8'h38) ||
           (q == 8'h50) || (q == 8'h51) || (q == 8'h52) || (q == 8'h6B) ||
           (q == 8'hC8);
  endfunction

endpackage

FILE: rtl/esfp_in_stage.sv
module esfp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  esfp_pkg::byte_t    in_rx_byte,
  input  logic               hold,
  output logic               in_stall,
  output logic               byte_valid,
  output esfp_pkg::byte_t    byte_data
);

  logic            valid_r;
  esfp_pkg::byte_t byte_r;

  assign in_stall = valid_r && hold;
  assign byte_valid = valid_r;
  assign byte_data = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

FILE: rtl/esfp_framer.sv
module esfp_framer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_fire,
  input  esfp_pkg::byte_t    rx_byte,
  output logic               at_last,
  output esfp_pkg::result_t  res
);

  esfp_pkg::pos_t  pos_r, pos_nxt;
  esfp_pkg::byte_t sum_r, sum_nxt;
  esfp_pkg::byte_t quality_r, quality_nxt;
  esfp_pkg::byte_t pend_att_r, pend_att_nxt;
  esfp_pkg::byte_t pend_med_r, pend_med_nxt;
  esfp_pkg::byte_t held_att_r, held_att_nxt;
  esfp_pkg::byte_t held_med_r, held_med_nxt;
  esfp_pkg::status_t status;
  esfp_pkg::byte_t want;
  logic            header_pos;

  assign at_last = (pos_r == esfp_pkg::POS_CHECKSUM);

  always_comb begin
    header_pos = 1'b1;
    unique case (pos_r)
      esfp_pkg::POS_SYNC0:  want = esfp_pkg::SYNC_BYTE;
      esfp_pkg::POS_SYNC1:  want = esfp_pkg::SYNC_BYTE;
      esfp_pkg::POS_LENGTH: want = esfp_pkg::LENGTH_BYTE;
      esfp_pkg::POS_CODE:   want = esfp_pkg::CODE_BYTE;
      esfp_pkg::POS_ASIC0:  want = esfp_pkg::ASIC0_BYTE;
      esfp_pkg::POS_ASIC1:  want = esfp_pkg::ASIC1_BYTE;
      default: begin
        want = esfp_pkg::SYNC_BYTE;
        header_pos = 1'b0;
      end
    endcase
  end

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    quality_nxt = quality_r;
    pend_att_nxt = pend_att_r;
    pend_med_nxt = pend_med_r;
    held_att_nxt = held_att_r;
    held_med_nxt = held_med_r;
    status = esfp_pkg::STATUS_OK;
    if (byte_fire) begin
      priority if (header_pos) begin
        if (pos_r == esfp_pkg::POS_CODE) begin
          sum_nxt = '0;
        end
        if (rx_byte == want) begin
          pos_nxt = pos_r + esfp_pkg::pos_t'(1);
          if (pos_r == esfp_pkg::POS_CODE) begin
            sum_nxt = rx_byte;
          end else if (pos_r == esfp_pkg::POS_ASIC0 || pos_r == esfp_pkg::POS_ASIC1) begin
            sum_nxt = sum_r + rx_byte;
          end
        end else begin
          pos_nxt = esfp_pkg::POS_SYNC0;
        end
      end else if (pos_r == esfp_pkg::POS_CHECKSUM) begin
        pos_nxt = esfp_pkg::POS_SYNC0;
        if (~sum_r != rx_byte) begin
          status = esfp_pkg::STATUS_CHECKSUM_ERR;
        end else if (esfp_pkg::is_poor_quality(quality_r)) begin
          status = esfp_pkg::STATUS_POOR_SIGNAL;
        end else begin
          held_att_nxt = pend_att_r;
          held_med_nxt = pend_med_r;
        end
      end else if (pos_r > esfp_pkg::POS_CHECKSUM) begin
        pos_nxt = esfp_pkg::POS_SYNC0;
      end else begin
        if (pos_r == esfp_pkg::POS_QUALITY) begin
          quality_nxt = rx_byte;
        end else if (pos_r == esfp_pkg::POS_ATTENTION) begin
          pend_att_nxt = rx_byte;
        end else if (pos_r == esfp_pkg::POS_MEDITATION) begin
          pend_med_nxt = rx_byte;
        end
        sum_nxt = sum_r + rx_byte;
        pos_nxt = pos_r + esfp_pkg::pos_t'(1);
      end
    end
  end

  always_comb begin
    res.valid = byte_fire && at_last;
    res.status = status;
    res.attention = held_att_nxt;
    res.meditation = held_med_nxt;
    res.signal_quality = quality_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
      quality_r <= '0;
      pend_att_r <= '0;
      pend_med_r <= '0;
      held_att_r <= '0;
      held_med_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      quality_r <= quality_nxt;
      pend_att_r <= pend_att_nxt;
      pend_med_r <= pend_med_nxt;
      held_att_r <= held_att_nxt;
      held_med_r <= held_med_nxt;
    end
  end

endmodule

FILE: rtl/esfp_out_stage.sv
module esfp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  esfp_pkg::result_t   res,
  input  logic                out_stall,
  output logic                out_busy,
  output logic                out_valid,
  output esfp_pkg::status_t   out_status,
  output esfp_pkg::byte_t     out_held_att,
  output esfp_pkg::byte_t     out_held_med,
  output esfp_pkg::byte_t     out_signal_quality
);

  logic               valid_r;
  esfp_pkg::result_t  data_r;

  assign out_busy = valid_r && out_stall;
  assign out_valid = valid_r;
  assign out_status = data_r.status;
  assign out_held_att = data_r.attention;
  assign out_held_med = data_r.meditation;
  assign out_signal_quality = data_r.signal_quality;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!out_busy) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && !out_busy) begin
      data_r <= res;
    end
  end

endmodule

FILE: rtl/eeg_serial_frame_parser_core.sv
// Frame parser for a fixed 36-byte EEG headset packet, one serial byte per transfer.
// Input channel: in_valid / in_stall carry in_rx_byte. Output channel: out_valid /
// out_stall carry one result per packet: out_status (ok, checksum error, poor
// signal), held attention and meditation, and the packet's quality byte.
// Header bytes that do not match drop the byte and restart the search.
// Throughput: one byte per cycle while in_stall is low; the position counter and
// running sum are updated from the input register as each byte is taken.
// The checksum byte passes through the input register; when the framer takes
// it, the result is formed combinationally and loads into the output register,
// from which it transfers on out_valid / out_stall.
// A waiting result does not hold up header or payload bytes; only the next
// checksum byte waits in the input register while the output is stalled, and
// in_stall rises then.
// Reset (synchronous, rst_n low): position, sum, held attention and
// meditation clear to zero and both channel registers empty.
module eeg_serial_frame_parser_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [7:0]        out_held_att,
  output logic [7:0]        out_held_med,
  output logic [7:0]        out_signal_quality
);

  logic              byte_valid;
  esfp_pkg::byte_t   byte_data;
  logic              hold;
  logic              byte_fire;
  logic              at_last;
  logic              out_busy;
  esfp_pkg::result_t res;

  assign hold = at_last && out_busy;
  assign byte_fire = byte_valid && !hold;

  esfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .hold       (hold),
    .in_stall   (in_stall),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  esfp_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (byte_fire),
    .rx_byte   (byte_data),
    .at_last   (at_last),
    .res       (res)
  );

  esfp_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .res                (res),
    .out_stall          (out_stall),
    .out_busy           (out_busy),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_held_att       (out_held_att),
    .out_held_med       (out_held_med),
    .out_signal_quality (out_signal_quality)
  );

endmodule

FILE: rtl/esfp_checker.sv
`include "eeg_serial_frame_parser_core_defines.svh"

module esfp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic [7:0] out_held_att,
  input logic [7:0] out_held_med,
  input logic [7:0] out_signal_quality
);

  logic [25:0] out_payload;
  logic        status_legal;

  assign out_payload = {out_status, out_held_att, out_held_med, out_signal_quality};
  assign status_legal = (out_status == esfp_pkg::STATUS_OK) ||
                        (out_status == esfp_pkg::STATUS_CHECKSUM_ERR) ||
                        (out_status == esfp_pkg::STATUS_POOR_SIGNAL);

  `ESFP_ASSERT_NEXT(a_out_valid_holds, out_valid && out_stall, out_valid, "result dropped")
  `ESFP_ASSERT_NEXT(a_out_payload_holds, out_valid && out_stall, $stable(out_payload), "payload moved")
  `ESFP_ASSERT_NOW(a_status_legal, out_valid, status_legal, "illegal status code")
  `ESFP_ASSERT_NOW(a_result_follows_byte, $rose(out_valid), $past(in_valid && !in_stall, 2), "no byte")

endmodule

bind eeg_serial_frame_parser_core esfp_checker u_esfp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_held_att       (out_held_att),
  .out_held_med       (out_held_med),
  .out_signal_quality (out_signal_quality)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned FRAME_BYTES = 36;
  localparam int unsigned PHASE_BYTES = 320;
  localparam int unsigned PHASE_FRAMES = 8;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam esfp_pkg::byte_t POOR_QUALITY_CODES [9] = '{
    8'h1D, 8'h36, 8'h37, 8'h38, 8'h50, 8'h51, 8'h52, 8'h6B, 8'hC8
  };

  typedef struct packed {
    esfp_pkg::status_t status;
    esfp_pkg::byte_t   attention;
    esfp_pkg::byte_t   meditation;
    esfp_pkg::byte_t   quality;
  } frame_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  esfp_pkg::byte_t   in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  esfp_pkg::status_t out_status;
  esfp_pkg::byte_t   out_held_att;
  esfp_pkg::byte_t   out_held_med;
  esfp_pkg::byte_t   out_signal_quality;

  esfp_pkg::pos_t  frame_pos;
  esfp_pkg::byte_t frame_sum;
  esfp_pkg::byte_t frame_quality;
  esfp_pkg::byte_t pend_attention;
  esfp_pkg::byte_t pend_meditation;
  esfp_pkg::byte_t held_attention;
  esfp_pkg::byte_t held_meditation;

  frame_result_t frame_results_due[$];
  int unsigned   bytes_sent;
  int unsigned   frames_closed;
  int unsigned   mismatch_count;
  int unsigned   quiet_cycles;
  int unsigned   sender_idle_pct;
  int unsigned   recv_stall_pct;

  eeg_serial_frame_parser_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_held_att      (out_held_att),
    .out_held_med      (out_held_med),
    .out_signal_quality(out_signal_quality)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic bit quality_is_poor(input esfp_pkg::byte_t q);
    foreach (POOR_QUALITY_CODES[i]) begin
      if (POOR_QUALITY_CODES[i] == q) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic esfp_pkg::pos_t next_pos_on_match(input esfp_pkg::byte_t b,
                                                       input esfp_pkg::byte_t want);
    return (b == want) ? esfp_pkg::pos_t'(frame_pos + 1'b1) : esfp_pkg::POS_SYNC0;
  endfunction

  task automatic clear_frame_state();
    frame_pos = esfp_pkg::POS_SYNC0;
    frame_sum = '0;
    frame_quality = '0;
    pend_attention = '0;
    pend_meditation = '0;
    held_attention = '0;
    held_meditation = '0;
  endtask

  task automatic track_frame_byte(input esfp_pkg::byte_t b);
    frame_result_t   res;
    esfp_pkg::byte_t asic_want;
    case (frame_pos)
      esfp_pkg::POS_SYNC0, esfp_pkg::POS_SYNC1: begin
        frame_pos = next_pos_on_match(b, esfp_pkg::SYNC_BYTE);
      end
      esfp_pkg::POS_LENGTH: frame_pos = next_pos_on_match(b, esfp_pkg::LENGTH_BYTE);
      esfp_pkg::POS_CODE: begin
        frame_sum = (b == esfp_pkg::CODE_BYTE) ? b : '0;
        frame_pos = next_pos_on_match(b, esfp_pkg::CODE_BYTE);
      end
      esfp_pkg::POS_ASIC0, esfp_pkg::POS_ASIC1: begin
        asic_want = (frame_pos == esfp_pkg::POS_ASIC0) ? esfp_pkg::ASIC0_BYTE
                                                       : esfp_pkg::ASIC1_BYTE;
        if (b == asic_want) begin
          frame_sum = frame_sum + b;
        end
        frame_pos = next_pos_on_match(b, asic_want);
      end
      esfp_pkg::POS_CHECKSUM: begin
        frame_pos = esfp_pkg::POS_SYNC0;
        if (esfp_pkg::byte_t'(~frame_sum) != b) begin
          res.status = esfp_pkg::STATUS_CHECKSUM_ERR;
        end else if (quality_is_poor(frame_quality)) begin
          res.status = esfp_pkg::STATUS_POOR_SIGNAL;
        end else begin
          res.status = esfp_pkg::STATUS_OK;
          held_attention = pend_attention;
          held_meditation = pend_meditation;
        end
        res.attention = held_attention;
        res.meditation = held_meditation;
        res.quality = frame_quality;
        frame_results_due.push_back(res);
        frames_closed++;
      end
      default: begin
        if (frame_pos > esfp_pkg::POS_CHECKSUM) begin
          frame_pos = esfp_pkg::POS_SYNC0;
        end else begin
          if (frame_pos == esfp_pkg::POS_QUALITY) frame_quality = b;
          if (frame_pos == esfp_pkg::POS_ATTENTION) pend_attention = b;
          if (frame_pos == esfp_pkg::POS_MEDITATION) pend_meditation = b;
          frame_sum = frame_sum + b;
          frame_pos = esfp_pkg::pos_t'(frame_pos + 1'b1);
        end
      end
    endcase
  endtask

  task automatic send_byte(input esfp_pkg::byte_t b);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    track_frame_byte(b);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_results_due.size() != 0) @(posedge clk);
  endtask

  function automatic esfp_pkg::byte_t pick_quality();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return POOR_QUALITY_CODES[$urandom_range(8)];
    if (r < 30) return 8'h00;
    if (r < 35) return 8'hFF;
    return esfp_pkg::byte_t'($urandom);
  endfunction

  function automatic esfp_pkg::byte_t pick_reading();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return esfp_pkg::byte_t'($urandom);
  endfunction

  task automatic send_frame(input esfp_pkg::byte_t quality, input esfp_pkg::byte_t attention,
                            input esfp_pkg::byte_t meditation, input bit corrupt_sum);
    esfp_pkg::byte_t pkt [FRAME_BYTES];
    esfp_pkg::byte_t sum;
    // realign to a frame start so the packet is parsed whole
    while (frame_pos != esfp_pkg::POS_SYNC0) send_byte(8'h00);
    pkt[esfp_pkg::POS_SYNC0] = esfp_pkg::SYNC_BYTE;
    pkt[esfp_pkg::POS_SYNC1] = esfp_pkg::SYNC_BYTE;
    pkt[esfp_pkg::POS_LENGTH] = esfp_pkg::LENGTH_BYTE;
    pkt[esfp_pkg::POS_CODE] = esfp_pkg::CODE_BYTE;
    pkt[esfp_pkg::POS_QUALITY] = quality;
    pkt[esfp_pkg::POS_ASIC0] = esfp_pkg::ASIC0_BYTE;
    pkt[esfp_pkg::POS_ASIC1] = esfp_pkg::ASIC1_BYTE;
    for (int i = esfp_pkg::POS_ASIC1 + 1; i < esfp_pkg::POS_CHECKSUM; i++) begin
      pkt[i] = esfp_pkg::byte_t'($urandom);
    end
    pkt[esfp_pkg::POS_ATTENTION] = attention;
    pkt[esfp_pkg::POS_MEDITATION] = meditation;
    sum = '0;
    for (int i = esfp_pkg::POS_CODE; i < esfp_pkg::POS_CHECKSUM; i++) sum = sum + pkt[i];
    pkt[esfp_pkg::POS_CHECKSUM] = ~sum;
    if (corrupt_sum) begin
      pkt[esfp_pkg::POS_CHECKSUM] ^= esfp_pkg::byte_t'($urandom_range(1, 255));
    end
    foreach (pkt[i]) send_byte(pkt[i]);
  endtask

  task automatic send_broken_header();
    esfp_pkg::byte_t hdr [7];
    esfp_pkg::byte_t wrong;
    int unsigned     cut;
    hdr = '{esfp_pkg::SYNC_BYTE, esfp_pkg::SYNC_BYTE, esfp_pkg::LENGTH_BYTE,
            esfp_pkg::CODE_BYTE, pick_quality(), esfp_pkg::ASIC0_BYTE,
            esfp_pkg::ASIC1_BYTE};
    do cut = $urandom_range(6); while (cut == esfp_pkg::POS_QUALITY);
    wrong = $urandom_range(1) ? esfp_pkg::SYNC_BYTE : esfp_pkg::byte_t'($urandom);
    if (wrong == hdr[cut]) wrong ^= 8'h01;
    for (int i = 0; i < cut; i++) send_byte(hdr[i]);
    send_byte(wrong);
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      send_byte(($urandom_range(99) < 30) ? esfp_pkg::SYNC_BYTE : esfp_pkg::byte_t'($urandom));
    end
  endtask

  task automatic report_mismatch(input string what, input frame_result_t want,
                                 input frame_result_t got);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("%0t: %s: expected status %0d att %0h med %0h q %0h,",
               $time, what, want.status, want.attention, want.meditation, want.quality,
               " got status %0d att %0h med %0h q %0h",
               got.status, got.attention, got.meditation, got.quality);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_held_att, out_held_med, out_signal_quality};
      if (frame_results_due.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = frame_results_due.pop_front();
        if (got.status != want.status || got.attention != want.attention ||
            got.meditation != want.meditation || got.quality != want.quality) begin
          report_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("eeg_serial_frame_parser_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_header_restart();
    // AA at the length position is dropped, not taken as a new sync
    send_byte(esfp_pkg::SYNC_BYTE);
    send_byte(esfp_pkg::SYNC_BYTE);
    send_byte(esfp_pkg::SYNC_BYTE);
    send_byte(esfp_pkg::LENGTH_BYTE);
    send_byte(esfp_pkg::CODE_BYTE);
    send_byte(esfp_pkg::SYNC_BYTE);
    send_byte(esfp_pkg::SYNC_BYTE);
    send_byte(esfp_pkg::LENGTH_BYTE);
    send_byte(esfp_pkg::CODE_BYTE);
    send_byte(8'h00);
    send_byte(esfp_pkg::SYNC_BYTE);
    send_byte(8'hFF);
    send_frame(8'h00, 8'hFF, 8'h00, 1'b0);
  endtask

  task automatic test_frame_outcomes();
    send_frame(8'hFF, 8'h00, 8'hFF, 1'b0);
    send_frame(8'hC8, 8'h12, 8'h34, 1'b0);
    send_frame(8'h1D, 8'h56, 8'h78, 1'b1);
    send_frame(8'h00, 8'h9A, 8'hBC, 1'b1);
    send_frame(8'h7F, 8'h80, 8'h01, 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned bytes_start;
    int unsigned frames_start;
    bit paused;
    int unsigned r;
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    bytes_start = bytes_sent;
    frames_start = frames_closed;
    paused = 1'b0;
    while (bytes_sent - bytes_start < PHASE_BYTES ||
           frames_closed - frames_start < PHASE_FRAMES) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_frame(pick_quality(), pick_reading(), pick_reading(), $urandom_range(99) < 20);
      end else if (r < 85) begin
        send_broken_header();
      end else begin
        send_noise();
      end
      if (!paused && frames_closed - frames_start >= PHASE_FRAMES / 2) begin
        pause_until_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    bytes_sent = 0;
    frames_closed = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    clear_frame_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_restart();
    test_frame_outcomes();
    test_random_traffic(0, 0);
    test_random_traffic(65, 0);
    test_random_traffic(0, 65);
    test_random_traffic(24, 24);

    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && frame_results_due.size() == 0) begin
      $display("eeg_serial_frame_parser_core regression: pass");
    end else begin
      $display("eeg_serial_frame_parser_core regression: fail");
    end
    $finish;
  end

endmodule
